@@ design/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
package ple_pkg;

   // Fixed field widths of the request and response beats
   localparam int OP_W     = 2;
   localparam int POS_W    = 5;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   // Slot indexes and counts inside the chain (covers the largest supported depth)
   localparam int SLOT_W = 8;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic                    found;
      logic signed [VAL_W-1:0] read_value;
      logic [LEN_W-1:0]        length;
   } rsp_type;

   // Broadcast edit command: insert or delete at a slot
   typedef struct packed {
      logic              apply;
      logic              del;
      logic [SLOT_W-1:0] slot;
      logic [VAL_W-1:0]  value;
   } cmd_type;

   // Query token walking down the chain, one cell per cycle
   typedef struct packed {
      logic              valid;
      logic              is_read;
      logic [SLOT_W-1:0] rem;    // occupied cells still ahead
      logic [SLOT_W-1:0] idx;    // 1-based countdown to the read target
      logic [VAL_W-1:0]  key;
      logic              found;
      logic [VAL_W-1:0]  rd;
   } token_type;

   typedef enum logic {
      PLE_IDLE,
      PLE_SCAN
   } state_type;

endpackage

@@ design/ple_cell.sv @@
// One list slot: holds an entry, shifts on edits, and checks a passing query token.
module ple_cell #(
   parameter int IDX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ple_pkg::cmd_type              cmd,
   input  logic [ple_pkg::VAL_W-1:0]     left_entry,
   input  logic [ple_pkg::VAL_W-1:0]     right_entry,
   output logic [ple_pkg::VAL_W-1:0]     entry,
   input  ple_pkg::token_type            tok_prev,
   output ple_pkg::token_type            tok_out
);
   import ple_pkg::*;

   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

   logic [VAL_W-1:0] entry_ff;
   logic [VAL_W-1:0] entry_in;
   token_type        tok_ff;
   token_type        tok_in;
   logic             occupied;

   assign entry = entry_ff;
   assign tok_out = tok_ff;

   // edits: insert takes left neighbor above the slot, delete takes right neighbor
   always_comb begin
      entry_in = entry_ff;
      if (cmd.apply) begin
         if (cmd.del) begin
            if (cmd.slot <= MY_SLOT) begin
               entry_in = right_entry;
            end
         end else begin
            if (cmd.slot == MY_SLOT) begin
               entry_in = cmd.value;
            end else if (cmd.slot < MY_SLOT) begin
               entry_in = left_entry;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign occupied = (tok_prev.rem != '0);

   always_comb begin
      tok_in     = tok_prev;
      tok_in.rem = tok_prev.rem - SLOT_W'(occupied);
      tok_in.idx = tok_prev.idx - SLOT_W'(tok_prev.idx != '0);
      if (!tok_prev.is_read && occupied && (entry_ff == tok_prev.key)) begin
         tok_in.found = 1'b1;
      end
      if (tok_prev.is_read && (tok_prev.idx == SLOT_W'(1))) begin
         tok_in.rd = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

endmodule

@@ design/positional_list_engine.sv @@
// Top level of the positional list engine: cell chain, control and response buffering.
//
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells, one
// value per cell, slot 0 first. Insert and delete are applied to every cell at once:
// each cell takes its own value, its left neighbor's, its right neighbor's or the
// new value, and the edit's response is registered in the response buffer. Search
// and read launch a token into cell 0 that moves one cell per cycle and collects
// the match flag or the addressed value on its way; the block accepts no new beat
// until the token leaves the last cell. Out-of-range requests, delete on an empty
// list and insert into a full list finish with a status code and leave the list
// untouched. A two-deep response buffer lets the block take one more beat while a
// finished response is stalled; req_stall rises when both slots hold results or a
// token is in flight. No clearing pass after reset: only occupied slots are ever
// read. length reports the list size after the operation.
module positional_list_engine #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ple_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ple_pkg::rsp_type rsp_item
);
   import ple_pkg::*;

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = SLOT_W + 1;

   // list size
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // response register plus one skid entry
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;

   state_type state_ff, state_in;
   logic      busy;

   logic            accept;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] cnt_x;
   logic            pos_ok_ins;
   logic            pos_ok_at;
   logic            is_full;
   logic            do_insert;
   logic            do_delete;
   logic            launch;
   logic            produce;
   rsp_type         produce_rsp;
   logic            take;

   cmd_type          cmd;
   token_type        tok_w [0:CAPACITY];
   logic [VAL_W-1:0] entry_w [0:CAPACITY-1];

   assign accept = req_valid && !req_stall;
   assign take   = rsp_valid_ff && !rsp_stall;

   // range checks on zero-extended position and count
   assign pos_x      = CMP_W'(req_item.position);
   assign cnt_x      = CMP_W'(count_ff);
   assign pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
   assign pos_ok_at  = (pos_x != '0) && (pos_x <= cnt_x);
   assign is_full    = (count_ff == CW'(CAPACITY));

   assign do_insert = accept && (req_item.op == OP_INSERT) && pos_ok_ins && !is_full;
   assign do_delete = accept && (req_item.op == OP_DELETE) && pos_ok_at;
   assign launch    = accept && ((req_item.op == OP_SEARCH) ||
                                 ((req_item.op == OP_READ) && pos_ok_at));

   // edit broadcast to all cells
   always_comb begin
      cmd.apply = do_insert || do_delete;
      cmd.del   = (req_item.op == OP_DELETE);
      cmd.slot  = SLOT_W'(pos_x - CMP_W'(1));
      cmd.value = req_item.value;
   end

   // query token entering cell 0
   always_comb begin
      tok_w[0].valid   = launch;
      tok_w[0].is_read = (req_item.op == OP_READ);
      tok_w[0].rem     = SLOT_W'(count_ff);
      tok_w[0].idx     = SLOT_W'(req_item.position);
      tok_w[0].key     = req_item.value;
      tok_w[0].found   = 1'b0;
      tok_w[0].rd      = '0;
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         ple_cell #(
            .IDX (gi)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .left_entry  (entry_w[(gi == 0) ? 0 : gi - 1]),
            .right_entry (entry_w[(gi == CAPACITY - 1) ? gi : gi + 1]),
            .entry       (entry_w[gi]),
            .tok_prev    (tok_w[gi]),
            .tok_out     (tok_w[gi + 1])
         );
      end
   endgenerate

   // next list size
   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CW'(1);
      end else if (do_delete) begin
         count_in = count_ff - CW'(1);
      end
   end

   // state machine: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PLE_IDLE: begin
            if (launch) begin
               state_in = PLE_SCAN;
            end
         end
         PLE_SCAN: begin
            if (tok_w[CAPACITY].valid) begin
               state_in = PLE_IDLE;
            end
         end
         default: state_in = PLE_IDLE;
      endcase
   end

   // state machine: outputs
   always_comb begin
      case (state_ff)
         PLE_IDLE: busy = 1'b0;
         PLE_SCAN: busy = 1'b1;
         default:  busy = 1'b0;
      endcase
   end

   assign req_stall = busy || pend_valid_ff;

   // finished results: edits and rejects right away, queries when the token exits
   always_comb begin
      produce                = 1'b0;
      produce_rsp.status     = ST_DONE;
      produce_rsp.found      = 1'b0;
      produce_rsp.read_value = '0;
      produce_rsp.length     = LEN_W'(count_in);
      if (tok_w[CAPACITY].valid) begin
         produce                = 1'b1;
         produce_rsp.found      = tok_w[CAPACITY].found;
         produce_rsp.read_value = tok_w[CAPACITY].rd;
         produce_rsp.length     = LEN_W'(count_ff);
      end else if (accept && !launch) begin
         produce = 1'b1;
         case (req_item.op)
            OP_INSERT: begin
               if (!pos_ok_ins) begin
                  produce_rsp.status = ST_RANGE;
               end else if (is_full) begin
                  produce_rsp.status = ST_FULL;
               end
            end
            OP_DELETE: begin
               if (!pos_ok_at) begin
                  produce_rsp.status = ST_RANGE;
               end
            end
            OP_READ:   produce_rsp.status = ST_RANGE;
            default:   produce_rsp.status = ST_DONE;
         endcase
      end
   end

   // response register and skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (pend_valid_ff) begin
         if (take) begin
            rsp_in        = pend_ff;
            pend_valid_in = 1'b0;
         end
      end else if (produce) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_in       = produce_rsp;
         end else begin
            pend_valid_in = 1'b1;
            pend_in       = produce_rsp;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         state_ff      <= PLE_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ dv/tb_positional_list_engine.sv @@
// Self-checking testbench for the positional list engine: random traffic, scoreboard, watchdog.
`timescale 1ns / 1ps

module tb_positional_list_engine;
   import ple_pkg::*;

   localparam int CAP       = 16;
   localparam int IDLE_MAX  = 3000;   // cycles with no beat on either side before giving up
   localparam int N_RANDOM  = 925;
   localparam int HOLD_LEN  = 250;    // long receiver hold-off, in cycles

   // Shadow of the list: element count plus the values, slot 0 first
   typedef struct packed {
      logic [LEN_W-1:0]            len;
      logic [CAP-1:0][VAL_W-1:0]   vals;
   } list_state_type;

   // One queued request; drain makes the sender wait for all responses first
   typedef struct packed {
      logic    drain;
      req_type item;
   } req_plan_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   positional_list_engine #(.CAPACITY(CAP)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   req_plan_type   pending_req_q[$];
   rsp_type        expected_rsp_q[$];
   list_state_type plan_state = '0;   // generator's view, used only to steer stimulus
   list_state_type list_model = '0;   // advanced on accepted beats, source of expectations

   int mismatches = 0;
   int orphan_rsps = 0;
   int op_cnt[4] = '{default: 0};
   int status_cnt[4] = '{default: 0};
   int found_hits = 0;
   int max_len = 0;

   // ------------------------------------------------------------------
   // List behavior: apply one request to a list state, return the new
   // state and the response it yields.
   //  - insert: position 1..len+1, later values move up; a bad position is
   //    reported as out of range even when the list is full
   //  - delete: position 1..len, later values move down; empty list and
   //    position zero are out of range
   //  - search: always done, found only among occupied slots
   //  - read: value at 1..len, zero with out-of-range status otherwise
   // ------------------------------------------------------------------
   function automatic list_state_type list_apply(input list_state_type s, input req_type r,
                                                 output rsp_type rsp);
      list_state_type n;
      int p;
      int len;
      int i;
      n   = s;
      p   = r.position;
      len = s.len;
      rsp = '0;
      case (r.op)
         OP_INSERT: begin
            if (p < 1 || p > len + 1) begin
               rsp.status = ST_RANGE;
            end else if (len >= CAP) begin
               rsp.status = ST_FULL;
            end else begin
               for (i = len; i >= p; i--) n.vals[i] = s.vals[i-1];
               n.vals[p-1] = r.value;
               n.len = LEN_W'(len + 1);
            end
         end
         OP_DELETE: begin
            if (p < 1 || p > len) begin
               rsp.status = ST_RANGE;
            end else begin
               for (i = p - 1; i < len - 1; i++) n.vals[i] = s.vals[i+1];
               n.len = LEN_W'(len - 1);
            end
         end
         OP_SEARCH: begin
            for (i = 0; i < len; i++)
               if (s.vals[i] == r.value) rsp.found = 1'b1;
         end
         OP_READ: begin
            if (p < 1 || p > len) rsp.status = ST_RANGE;
            else rsp.read_value = s.vals[p-1];
         end
         default: ;
      endcase
      rsp.length = n.len;
      return n;
   endfunction

   // Queue one request and advance the generator's list view
   task automatic plan_req(input logic [OP_W-1:0] op, input int pos,
                           input logic [VAL_W-1:0] val, input bit drain);
      req_type      r;
      rsp_type      ignored;
      req_plan_type pl;
      r.op       = op;
      r.position = pos[POS_W-1:0];
      r.value    = val;
      pl.drain   = drain;
      pl.item    = r;
      pending_req_q.push_back(pl);
      plan_state = list_apply(plan_state, r, ignored);
   endtask

   // ------------------------------------------------------------------
   // Sender: bursts of random length with random gaps. A beat that is
   // stalled stays put. A plan marked drain is held back until every
   // outstanding response has been seen.
   // ------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin : sender
      rsp_type      exp;
      req_plan_type pl;
      if (reset) begin
         req_valid  <= 1'b0;
         list_model = '0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            // beat accepted at this edge: predict its response
            list_model = list_apply(list_model, req_item, exp);
            expected_rsp_q.push_back(exp);
            op_cnt[req_item.op]++;
            status_cnt[exp.status]++;
            if (exp.found) found_hits++;
            if (exp.length > max_len) max_len = exp.length;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_req_q.size() != 0 &&
                      !(pending_req_q[0].drain && expected_rsp_q.size() != 0)) begin
            pl = pending_req_q.pop_front();
            req_item  <= pl.item;
            req_valid <= 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               // a quarter of the bursts run straight into the next one
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: stall pattern switches between modes every so often, and
   // twice holds off for a long stretch so the block backs up onto its
   // input. The trigger counts responses taken here, in this process.
   // ------------------------------------------------------------------
   int rcv_cnt = 0;
   int hold_left = 0;
   int holds_done = 0;
   int stall_mode = 0;
   int mode_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) rcv_cnt++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if ((holds_done == 0 && rcv_cnt >= 300) ||
                      (holds_done == 1 && rcv_cnt >= 700)) begin
            hold_left = HOLD_LEN;
            holds_done++;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(20, 200);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: rsp_stall <= 1'b0;                          // free flowing
               1: rsp_stall <= ($urandom_range(0, 3) == 0);   // light
               2: rsp_stall <= ($urandom_range(0, 3) != 0);   // heavy
               default: rsp_stall <= ~rsp_stall;              // alternating
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Scoreboard: each response beat against the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      rsp_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            orphan_rsps++;
            $display("[%0t] response beat with nothing outstanding: st=%0d f=%0d rd=%0d len=%0d",
                     $time, rsp_item.status, rsp_item.found, rsp_item.read_value,
                     rsp_item.length);
         end else begin
            exp = expected_rsp_q.pop_front();
            if (rsp_item.status !== exp.status || rsp_item.found !== exp.found ||
                rsp_item.read_value !== exp.read_value || rsp_item.length !== exp.length) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("[%0t] mismatch: exp st=%0d f=%0d rd=%0d len=%0d",
                           $time, exp.status, exp.found, exp.read_value, exp.length);
                  $display("          got st=%0d f=%0d rd=%0d len=%0d",
                           rsp_item.status, rsp_item.found, rsp_item.read_value,
                           rsp_item.length);
               end
            end
         end
      end
   end

   // Watchdog: too long with no beat on either channel means a hang
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_MAX) begin
         $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                  idle_cycles, expected_rsp_q.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   logic [VAL_W-1:0] val_pool[8] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                     32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd42};

   initial begin : stimulus
      int               n;
      int               bias;
      int               k;
      int               len;
      int               hi;
      int               pos;
      logic [OP_W-1:0]  op;
      logic [VAL_W-1:0] val;
      bit               drain;

      // Directed: empty-list corner cases
      plan_req(OP_READ,   1, 32'd7, 0);              // read on empty list
      plan_req(OP_DELETE, 1, 32'd0, 0);              // delete on empty list
      plan_req(OP_DELETE, 0, 32'd0, 0);              // delete at position zero
      plan_req(OP_SEARCH, 0, 32'd0, 0);              // search on empty list
      plan_req(OP_INSERT, 0, 32'd5, 0);              // insert at position zero
      plan_req(OP_INSERT, 2, 32'd5, 0);              // insert past length+1
      // build a short list with the value extremes, head / tail / middle inserts
      plan_req(OP_INSERT, 1, 32'h7FFF_FFFF, 0);
      plan_req(OP_INSERT, 1, 32'h8000_0000, 0);
      plan_req(OP_INSERT, 3, 32'hFFFF_FFFF, 0);
      plan_req(OP_INSERT, 2, 32'd0, 0);
      plan_req(OP_SEARCH, 0, 32'h8000_0000, 0);      // hit at head
      plan_req(OP_SEARCH, 31, 32'hFFFF_FFFF, 0);     // hit at tail
      plan_req(OP_SEARCH, 0, 32'd12345, 0);          // miss
      plan_req(OP_READ,   1, 32'd0, 0);
      plan_req(OP_READ,   4, 32'd0, 0);              // last entry
      plan_req(OP_READ,   5, 32'd0, 0);              // one past the end
      plan_req(OP_READ,  31, 32'd0, 0);              // largest position encoding
      plan_req(OP_DELETE, 0, 32'd0, 0);
      plan_req(OP_DELETE, 5, 32'd0, 0);              // past the end
      plan_req(OP_DELETE, 4, 32'd0, 0);              // tail
      plan_req(OP_DELETE, 1, 32'd0, 0);              // head
      plan_req(OP_INSERT, 31, 32'd9, 0);             // far out of range
      plan_req(OP_READ,   2, 32'd0, 0);

      // Random: phases biased toward filling, draining or a mix, so the list
      // sweeps between empty and full many times
      bias = 0;
      for (n = 0; n < N_RANDOM; n++) begin
         if (n % 64 == 0 && n != 0) bias = $urandom_range(0, 2);
         k = $urandom_range(0, 99);
         case (bias)
            0:       op = (k < 60) ? OP_INSERT : (k < 70) ? OP_DELETE :
                          (k < 85) ? OP_SEARCH : OP_READ;
            1:       op = (k < 10) ? OP_INSERT : (k < 70) ? OP_DELETE :
                          (k < 85) ? OP_SEARCH : OP_READ;
            default: op = (k < 30) ? OP_INSERT : (k < 55) ? OP_DELETE :
                          (k < 80) ? OP_SEARCH : OP_READ;
         endcase

         len = plan_state.len;
         hi  = (op == OP_INSERT) ? len + 1 : len;
         k   = $urandom_range(0, 9);
         if (k < 8 && hi >= 1) pos = $urandom_range(1, hi);
         else if (k < 9)       pos = ($urandom_range(0, 1) == 0) ? 0 : hi + 1;
         else                  pos = $urandom_range(0, 31);

         k = $urandom_range(0, 9);
         if (op == OP_SEARCH && len > 0 && k < 5)
            val = plan_state.vals[$urandom_range(0, len - 1)];
         else if (k < 8)
            val = $urandom;
         else
            val = val_pool[$urandom_range(0, 7)];

         // sender waits for a full drain at the start, mid-run and now and then
         drain = (n == 0) || (n == 450) || ($urandom_range(0, 149) == 0);
         plan_req(op, pos, val, drain);
      end

      // End of run: everything sent, everything answered, then a settle window
      while (pending_req_q.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (CAP + 8) @(posedge clock);

      $display("beats: %0d insert, %0d delete, %0d search, %0d read; longest list %0d of %0d",
               op_cnt[OP_INSERT], op_cnt[OP_DELETE], op_cnt[OP_SEARCH], op_cnt[OP_READ],
               max_len, CAP);
      $display("outcomes: %0d done, %0d out of range, %0d full, %0d search hits; %0d mismatches",
               status_cnt[ST_DONE], status_cnt[ST_RANGE], status_cnt[ST_FULL], found_hits,
               mismatches);
      if (mismatches == 0 && orphan_rsps == 0 && expected_rsp_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
